FILE: hdl/oosc_pkg.sv
// Shared types and constants for the odd-only prime sieve counter.
package oosc_pkg;

    localparam int LIMIT_W    = 21;
    localparam int COUNT_W    = 17;
    localparam int DATA_IN_W  = 24;
    localparam int DATA_OUT_W = 24;

    // odd sieving prime and its square; p*p never passes the 21-bit limit by much
    localparam int P_W  = 12;
    localparam int SQ_W = 23;

    localparam longint unsigned LIMIT_TOP = (64'd1 << LIMIT_W) - 64'd1;
    localparam longint unsigned SLOT_TOP  = 64'd1 << (LIMIT_W - 1);

    typedef struct packed {
        logic load;        // capture limit, start a new request
        logic clear_wr;    // clear pass: write zero at the clear pointer
        logic sieve_init;  // i = 1, p = 3, sq = 9
        logic rd_i;        // read map bit i
        logic adv_i;       // next odd candidate
        logic mark_start;  // j = p*p/2
        logic mark_wr;     // mark j composite, j += p
        logic cnt_init;    // i = 1, count = 1
        logic cnt_rd;      // counting read at i, i++
    } cmd_t;

    typedef struct packed {
        logic small_n;     // limit below two
        logic clr_last;    // clear pointer at last slot
        logic sieve_done;  // p*p > n or candidates used up
        logic bit_set;     // registered map read data
        logic mark_end;    // j at or past slot count
        logic i_end;       // i at or past slot count
    } stat_t;

endpackage

FILE: hdl/oosc_ctrl.sv
// Sequencer for the clear, sieve, mark and count passes.
module oosc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_free,
    output logic           emit,
    input  oosc_pkg::stat_t stat,
    output oosc_pkg::cmd_t  cmd
);
    import oosc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_TEST  = 7'b0001000,
        S_MARK  = 7'b0010000,
        S_COUNT = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (stat.small_n)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.clear_wr = 1'b1;
                    if (stat.clr_last)
                    begin
                        cmd.sieve_init = 1'b1;
                        state_next     = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (stat.sieve_done)
                begin
                    cmd.cnt_init = 1'b1;
                    state_next   = S_COUNT;
                end
                else
                begin
                    cmd.rd_i   = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (stat.bit_set)
                begin
                    cmd.adv_i  = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.mark_start = 1'b1;
                    state_next     = S_MARK;
                end
            end
            S_MARK:
            begin
                if (stat.mark_end)
                begin
                    cmd.adv_i  = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.mark_wr = 1'b1;
                end
            end
            S_COUNT:
            begin
                if (stat.i_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.cnt_rd = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/oosc_datapath.sv
// Sieve datapath: bitmap memory, candidate and multiple counters, prime tally.
module oosc_datapath #(
    parameter longint unsigned MAX_LIMIT = 1048576
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  oosc_pkg::cmd_t                 cmd,
    input  logic [oosc_pkg::LIMIT_W-1:0]   limit,
    output oosc_pkg::stat_t                stat,
    output logic [oosc_pkg::COUNT_W-1:0]   prime_count
);
    import oosc_pkg::*;

    localparam longint unsigned MAP_BITS = MAX_LIMIT / 2;
    localparam longint unsigned DEPTH_L  = (MAP_BITS < SLOT_TOP) ? MAP_BITS : SLOT_TOP;
    localparam int DEPTH  = int'(DEPTH_L);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(DEPTH + 1);
    localparam int JW     = SLOT_W + 1;
    localparam longint unsigned CAP_L = (MAX_LIMIT < LIMIT_TOP) ? MAX_LIMIT : LIMIT_TOP;
    localparam logic [LIMIT_W-1:0] LIM_CAP = LIMIT_W'(CAP_L);

    logic                mem [DEPTH];

    logic [LIMIT_W-1:0]  n_reg,     n_next;
    logic [SLOT_W-1:0]   slots_reg, slots_next;
    logic [SLOT_W-1:0]   a_reg,     a_next;
    logic [SLOT_W-1:0]   i_reg,     i_next;
    logic [P_W-1:0]      p_reg,     p_next;
    logic [SQ_W-1:0]     sq_reg,    sq_next;
    logic [JW-1:0]       j_reg,     j_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                rd_data_reg;
    logic                rd_valid_reg;

    logic [LIMIT_W-1:0]  n_sat;
    logic [LIMIT_W:0]    n_plus;
    logic [LIMIT_W-1:0]  half;
    logic                we;
    logic                re;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   raddr;

    // request setup: saturate, then number of odd slots 1..n
    always_comb
    begin
        n_sat  = (limit > LIM_CAP) ? LIM_CAP : limit;
        n_plus = {1'b0, n_sat} + 1'b1;
        half   = n_plus[LIMIT_W:1];
    end

    always_comb
    begin
        n_next     = cmd.load ? n_sat : n_reg;
        slots_next = slots_reg;
        if (cmd.load)
        begin
            slots_next = (half > LIMIT_W'(DEPTH)) ? SLOT_W'(DEPTH) : SLOT_W'(half);
        end

        a_next = a_reg;
        if (cmd.load)
            a_next = '0;
        else if (cmd.clear_wr)
            a_next = a_reg + 1'b1;

        i_next  = i_reg;
        p_next  = p_reg;
        sq_next = sq_reg;
        if (cmd.sieve_init || cmd.cnt_init)
            i_next = SLOT_W'(1);
        else if (cmd.adv_i || cmd.cnt_rd)
            i_next = i_reg + 1'b1;
        if (cmd.sieve_init)
        begin
            p_next  = P_W'(3);
            sq_next = SQ_W'(9);
        end
        else if (cmd.adv_i)
        begin
            // (p+2)^2 = p^2 + 4p + 4
            p_next  = p_reg + P_W'(2);
            sq_next = sq_reg + SQ_W'({p_reg, 2'b00}) + SQ_W'(4);
        end

        j_next = j_reg;
        if (cmd.mark_start)
            j_next = JW'(sq_reg >> 1);
        else if (cmd.mark_wr)
            j_next = j_reg + JW'(p_reg);

        count_next = count_reg;
        if (cmd.load)
            count_next = '0;
        else if (cmd.cnt_init)
            count_next = COUNT_W'(1);    // the prime 2
        else if (rd_valid_reg && !rd_data_reg)
            count_next = count_reg + 1'b1;
    end

    // single-bit map: one write port, one registered read port
    always_comb
    begin
        we    = cmd.clear_wr || cmd.mark_wr;
        re    = cmd.rd_i || cmd.cnt_rd;
        waddr = cmd.clear_wr ? a_reg[ADDR_W-1:0] : j_reg[ADDR_W-1:0];
        raddr = i_reg[ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= cmd.mark_wr;
        if (re)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        slots_reg <= slots_next;
        a_reg     <= a_next;
        i_reg     <= i_next;
        p_reg     <= p_next;
        sq_reg    <= sq_next;
        j_reg     <= j_next;
        count_reg <= count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= cmd.cnt_rd;
    end

    always_comb
    begin
        stat.small_n    = n_reg < LIMIT_W'(2);
        stat.clr_last   = a_reg == (slots_reg - 1'b1);
        stat.i_end      = i_reg >= slots_reg;
        stat.sieve_done = (sq_reg > SQ_W'(n_reg)) || stat.i_end;
        stat.bit_set    = rd_data_reg;
        stat.mark_end   = j_reg >= JW'(slots_reg);
    end

    assign prime_count = count_reg;

`ifndef SYNTH
    // marks never land past the live part of the map
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_wr |-> (j_reg < JW'(slots_reg)))
        else $error("mark write beyond slot count");

    // incremental square tracks the candidate prime
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.adv_i || cmd.sieve_init) |=> (sq_reg == p_reg * p_reg))
        else $error("square register out of step with p");

    // a candidate is only tested while p*p is within the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_i |-> (sq_reg <= SQ_W'(n_reg) && i_reg < slots_reg))
        else $error("sieve read past p*p bound");
`endif

endmodule

FILE: hdl/odd_only_prime_sieve_counter.sv
// Top level of the odd-only prime sieve counter: sequencer, datapath, result register.
// For limit n >= 2, with s = (n+1)/2 odd slots, a request runs a clearing pass over the s
// slots, a check and a test read for each odd candidate p with p*p <= n plus a mark pass for
// each one that marks, one write per composite mark and s-1 counting reads; run time is set
// by the one-access-per-cycle map. Limits 0 and 1 go from the clear state straight to done
// without touching the map. One request at a time; the next is taken while the result waits
// in the output register. Reset clears control state only; the map is cleared at the start
// of every request, so no clearing pass follows reset.
module odd_only_prime_sieve_counter #(
    parameter longint unsigned MAX_LIMIT = 1048576
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [oosc_pkg::DATA_IN_W-1:0]    s_axis_tdata,   // [20:0] limit
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [oosc_pkg::DATA_OUT_W-1:0]   m_axis_tdata    // [16:0] prime_count
);
    import oosc_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic                emit;
    logic                out_free;
    logic [COUNT_W-1:0]  prime_count;

    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  out_data_reg,  out_data_next;

    // result register frees up in the same cycle the sink takes it
    assign out_free = !out_valid_reg || m_axis_tready;

    oosc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .emit     (emit),
        .stat     (stat),
        .cmd      (cmd)
    );

    oosc_datapath #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .limit       (s_axis_tdata[LIMIT_W-1:0]),
        .stat        (stat),
        .prime_count (prime_count)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = prime_count;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(DATA_OUT_W - COUNT_W){1'b0}}, out_data_reg};

`ifndef SYNTH
    // a taken request keeps the block busy for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    // a result is only written when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrites pending output");

    // the sequencer never commands a sieve step while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !(cmd.mark_wr || cmd.clear_wr || cmd.cnt_rd || cmd.rd_i))
        else $error("map access while idle");
`endif

endmodule

FILE: tb/sv/odd_only_prime_sieve_counter_test.sv
// Testbench for the odd-only prime sieve counter: directed and random limits, self-checking.
module odd_only_prime_sieve_counter_test;

    import oosc_pkg::*;

    localparam longint unsigned MAX_LIMIT = 1048576;
    localparam longint unsigned MAP_SLOTS = MAX_LIMIT / 2;

    // Timeout for the whole run, set well above any likely mix of large random limits.
    localparam longint unsigned RUN_LIMIT = 400_000_000;

    typedef struct {
        logic [LIMIT_W-1:0] limit;
        logic [COUNT_W-1:0] prime_count;
    } pending_count_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_IN_W-1:0]  s_axis_tdata = '0;   // [20:0] limit
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_axis_tdata;        // [16:0] prime_count

    // Counts still owed by the block, oldest first.
    pending_count_t awaited_counts[$];
    int mismatch_count = 0;

    // Sender idling: when set, requests go back to back.
    bit no_gap_stretch = 1'b0;

    // Receiver stall pattern state.
    int ready_left = 0;
    int stall_left = 0;

    // Predictor's own copy of the odd-number composite bitmap; bit i stands for 2i+1.
    bit sieve_marks [0:MAP_SLOTS-1];

    odd_only_prime_sieve_counter #(
        .MAX_LIMIT(MAX_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Odd-only sieve: saturate the limit, mark odd multiples from p*p on, count what is left.
    // Only the slots that this request reads are cleared; the rest are never looked at.
    function automatic logic [COUNT_W-1:0] count_primes(input logic [LIMIT_W-1:0] limit);
        longint unsigned n;
        longint unsigned slots;
        longint unsigned i;
        longint unsigned j;
        longint unsigned p;
        longint unsigned total;
        n = 64'(limit);
        if (n > MAX_LIMIT)
            n = MAX_LIMIT;
        if (n < 2)
            return '0;
        slots = (n + 1) / 2;
        if (slots > MAP_SLOTS)
            slots = MAP_SLOTS;
        for (i = 0; i < slots; i++)
            sieve_marks[i] = 1'b0;
        for (i = 1; i < slots; i++)
        begin
            p = 2 * i + 1;
            if (p * p > n)
                break;
            if (sieve_marks[i])
                continue;
            for (j = (p * p) / 2; j < slots; j += p)
                sieve_marks[j] = 1'b1;
        end
        total = 1;   // the prime 2
        for (i = 1; i < slots; i++)
            if (!sieve_marks[i])
                total++;
        return total[COUNT_W-1:0];
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // One request: optional idle gap, then hold tvalid until accepted. tvalid is left high
    // afterwards so back-to-back requests never drop it within a time step.
    task automatic send_limit(input logic [LIMIT_W-1:0] limit);
        int gap;
        pending_count_t entry;
        gap = no_gap_stretch ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(DATA_IN_W-LIMIT_W){1'b0}}, limit};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        entry.limit       = limit;
        entry.prime_count = count_primes(limit);
        awaited_counts.push_back(entry);
    endtask

    // Stop sending and wait for every owed count.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (awaited_counts.size() > 0)
            @(posedge clk);
    endtask

    // Result side: check every accepted count, then choose the next tready.
    always @(posedge clk)
    begin : result_side
        pending_count_t entry;
        int r;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_counts.size() == 0)
            begin
                note_failure($sformatf("unexpected result prime_count=%0d",
                                       m_axis_tdata[COUNT_W-1:0]));
            end
            else
            begin
                entry = awaited_counts.pop_front();
                if (m_axis_tdata[COUNT_W-1:0] !== entry.prime_count)
                    note_failure($sformatf("limit=%0d prime_count expected %0d got %0d",
                                           entry.limit, entry.prime_count,
                                           m_axis_tdata[COUNT_W-1:0]));
            end
        end
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (stall_left == 0 && ready_left == 0)
            begin
                r = $urandom_range(0, 99);
                // Some long ready stretches, otherwise short ready windows with stalls.
                ready_left = (r < 15) ? $urandom_range(50, 400) : $urandom_range(1, 8);
                stall_left = (r < 15) ? 0 : pick_gap();
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                ready_left--;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Limits below two, the first primes, and small powers of two.
    task automatic test_small_limits();
        send_limit(0);
        send_limit(1);
        send_limit(2);
        send_limit(3);
        send_limit(4);
        send_limit(5);
        send_limit(7);
        send_limit(8);
        send_limit(9);
    endtask

    // Limits on and around odd squares, where a new sieving prime just starts to mark, plus 1000 and 1024.
    task automatic test_square_edges();
        send_limit(24);
        send_limit(25);
        send_limit(48);
        send_limit(49);
        send_limit(120);
        send_limit(121);
        send_limit(1000);
        send_limit(1024);
    endtask

    // The full map, and an all-ones limit that must saturate to it. Between them every
    // limit bit below the top one is seen both low and high.
    task automatic test_limit_extremes();
        send_limit(MAX_LIMIT[LIMIT_W-1:0]);
        send_limit({LIMIT_W{1'b1}});
    endtask

    // Mostly small limits to keep the run short; a few mid-size and rare large ones.
    task automatic test_random_limits(input int n_items);
        int k;
        int r;
        logic [LIMIT_W-1:0] limit;
        for (k = 0; k < n_items; k++)
        begin
            // Alternate between stretches of back-to-back requests and gappy ones.
            if (k % 10 == 0)
                no_gap_stretch = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
                limit = LIMIT_W'($urandom_range(0, 2000));
            else if (r < 97)
                limit = LIMIT_W'($urandom_range(2001, 65535));
            else
                limit = LIMIT_W'($urandom_range(65536, 524287));
            send_limit(limit);
            // Once midway the sender holds off until everything owed has come back.
            if (k == n_items / 2)
                drain_results();
        end
        no_gap_stretch = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_limits();
        test_square_edges();
        drain_results();
        test_limit_extremes();
        test_random_limits(80);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule
